/* src/hrlc_pkg.sv */
// Shared types, codes and character helpers for the HTTP request-line checker.
package hrlc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned LEN_W    = 2;
    localparam int unsigned M_DATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_IMPL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_VERSION  = 2'd3;

    localparam logic KIND_PATH   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [LEN_W-1:0] PLEN_NONE  = 2'd0;
    localparam logic [LEN_W-1:0] PLEN_ROOT  = 2'd1;
    localparam logic [LEN_W-1:0] PLEN_OTHER = 2'd2;

    localparam logic [POS_W-1:0] GET_LEN     = 3'd3;
    localparam logic [POS_W-1:0] OPTIONS_LEN = 3'd7;
    localparam logic [POS_W-1:0] PROTO_LEN   = 3'd5;

    localparam logic [1:0] VER_ONE_ONE = 2'b11;

    typedef enum logic [11:0] {
        PH_METHOD   = 12'b0000_0000_0001,
        PH_WS_FIRST = 12'b0000_0000_0010,
        PH_WS_MORE  = 12'b0000_0000_0100,
        PH_PATH     = 12'b0000_0000_1000,
        PH_WS2      = 12'b0000_0001_0000,
        PH_PROTO    = 12'b0000_0010_0000,
        PH_MAJOR    = 12'b0000_0100_0000,
        PH_DOT      = 12'b0000_1000_0000,
        PH_MINOR    = 12'b0001_0000_0000,
        PH_CTRL1    = 12'b0010_0000_0000,
        PH_CTRL2    = 12'b0100_0000_0000,
        PH_TAIL     = 12'b1000_0000_0000
    } phase_t;

    // Request byte held in the input register.
    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   data_byte;
        logic                end_of_request;
    } in_item_t;

    // Result of one byte, ahead of the output register.
    typedef struct packed {
        logic                valid;
        logic                item_kind;
        logic [BYTE_W-1:0]   path_byte;
        logic [STATUS_W-1:0] status;
        logic                root_path;
    } result_t;

    function automatic logic is_ws(logic [BYTE_W-1:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_ctrl(logic [BYTE_W-1:0] c);
        return (c <= 8'h1F) || (c == 8'h7F);
    endfunction

    function automatic logic is_digit(logic [BYTE_W-1:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic [BYTE_W-1:0] get_char(logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd0:    ch = "G";
            3'd1:    ch = "E";
            3'd2:    ch = "T";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [BYTE_W-1:0] options_char(logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd0:    ch = "O";
            3'd1:    ch = "P";
            3'd2:    ch = "T";
            3'd3:    ch = "I";
            3'd4:    ch = "O";
            3'd5:    ch = "N";
            3'd6:    ch = "S";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [BYTE_W-1:0] proto_char(logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd0:    ch = "H";
            3'd1:    ch = "T";
            3'd2:    ch = "T";
            3'd3:    ch = "P";
            3'd4:    ch = "/";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* src/hrlc_in_reg.sv */
// Input register stage for request bytes.
module hrlc_in_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hrlc_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         take,
    output hrlc_pkg::in_item_t           item
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [hrlc_pkg::BYTE_W-1:0] byte_reg;
    logic                        last_reg;

    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign item.valid          = valid_reg;
    assign item.data_byte      = byte_reg;
    assign item.end_of_request = last_reg;

endmodule

/* src/hrlc_parser.sv */
// Request-line pattern matcher: parse state and per-byte result logic.
module hrlc_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hrlc_pkg::in_item_t      item,
    input  logic                    take,
    output hrlc_pkg::result_t       result
);

    hrlc_pkg::phase_t                phase_reg, phase_next;
    logic                            done_reg, done_next;
    logic [hrlc_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            opt_reg, opt_next;
    logic                            dot_reg, dot_next;
    logic                            dotdot_reg, dotdot_next;
    logic [hrlc_pkg::LEN_W-1:0]      plen_reg, plen_next;
    logic [1:0]                      ver_reg, ver_next;
    logic                            failed_reg, failed_next;

    logic [hrlc_pkg::BYTE_W-1:0]     c;
    logic                            do_path;
    logic [hrlc_pkg::POS_W-1:0]      mlen;
    logic [hrlc_pkg::BYTE_W-1:0]     mchar;
    logic [hrlc_pkg::STATUS_W-1:0]   status;
    logic                            root;

    assign c     = item.data_byte;
    assign mlen  = opt_reg ? hrlc_pkg::OPTIONS_LEN : hrlc_pkg::GET_LEN;
    assign mchar = opt_reg ? hrlc_pkg::options_char(pos_reg) : hrlc_pkg::get_char(pos_reg);

    always_comb begin
        phase_next  = phase_reg;
        done_next   = done_reg;
        pos_next    = pos_reg;
        opt_next    = opt_reg;
        dot_next    = dot_reg;
        dotdot_next = dotdot_reg;
        plen_next   = plen_reg;
        ver_next    = ver_reg;
        failed_next = failed_reg;
        do_path     = 1'b0;
        if (!failed_reg && !done_reg) begin
            case (phase_reg)
                hrlc_pkg::PH_METHOD: begin
                    if (pos_reg == '0) begin
                        if (c == "G") begin
                            opt_next = 1'b0;
                            pos_next = 3'd1;
                        end else if (c == "O") begin
                            opt_next = 1'b1;
                            pos_next = 3'd1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end else if (pos_reg >= mlen || c != mchar) begin
                        failed_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_next == mlen) begin
                            phase_next = hrlc_pkg::PH_WS_FIRST;
                            pos_next   = '0;
                        end
                    end
                end
                hrlc_pkg::PH_WS_FIRST: begin
                    if (hrlc_pkg::is_ws(c)) begin
                        phase_next = hrlc_pkg::PH_WS_MORE;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                hrlc_pkg::PH_WS_MORE: begin
                    if (!hrlc_pkg::is_ws(c)) begin
                        phase_next = hrlc_pkg::PH_PATH;
                        do_path    = 1'b1;
                    end
                end
                hrlc_pkg::PH_PATH: begin
                    if (hrlc_pkg::is_ws(c)) begin
                        phase_next = hrlc_pkg::PH_WS2;
                    end else begin
                        do_path = 1'b1;
                    end
                end
                hrlc_pkg::PH_WS2: begin
                    if (!hrlc_pkg::is_ws(c)) begin
                        if (c == hrlc_pkg::proto_char('0)) begin
                            phase_next = hrlc_pkg::PH_PROTO;
                            pos_next   = 3'd1;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                end
                hrlc_pkg::PH_PROTO: begin
                    if (pos_reg >= hrlc_pkg::PROTO_LEN || c != hrlc_pkg::proto_char(pos_reg)) begin
                        failed_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_next == hrlc_pkg::PROTO_LEN) begin
                            phase_next = hrlc_pkg::PH_MAJOR;
                            pos_next   = '0;
                        end
                    end
                end
                hrlc_pkg::PH_MAJOR: begin
                    if (hrlc_pkg::is_digit(c)) begin
                        ver_next[0] = ver_reg[0] | (c == "1");
                        phase_next  = hrlc_pkg::PH_DOT;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                hrlc_pkg::PH_DOT: begin
                    if (c == ".") begin
                        phase_next = hrlc_pkg::PH_MINOR;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                hrlc_pkg::PH_MINOR: begin
                    if (hrlc_pkg::is_digit(c)) begin
                        ver_next[1] = ver_reg[1] | (c == "1");
                        phase_next  = hrlc_pkg::PH_CTRL1;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                hrlc_pkg::PH_CTRL1: begin
                    if (hrlc_pkg::is_ctrl(c)) begin
                        phase_next = hrlc_pkg::PH_CTRL2;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                hrlc_pkg::PH_CTRL2: begin
                    if (hrlc_pkg::is_ctrl(c)) begin
                        phase_next = hrlc_pkg::PH_TAIL;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                hrlc_pkg::PH_TAIL: begin
                    if (c != 8'h0D && c != 8'h0A) begin
                        done_next = 1'b1;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                default: begin
                    failed_next = 1'b1;
                end
            endcase
        end
        if (do_path) begin
            dotdot_next = dotdot_reg | (dot_reg && c == ".");
            dot_next    = (c == ".");
            plen_next   = (plen_reg == hrlc_pkg::PLEN_NONE && c == "/") ?
                          hrlc_pkg::PLEN_ROOT : hrlc_pkg::PLEN_OTHER;
        end
    end

    always_comb begin
        status = hrlc_pkg::ST_INVALID;
        root   = 1'b0;
        if (!failed_next && done_next) begin
            root = (plen_next == hrlc_pkg::PLEN_ROOT);
            if (dotdot_next) begin
                status = hrlc_pkg::ST_INVALID;
            end else if (opt_next) begin
                status = hrlc_pkg::ST_NOT_IMPL;
            end else if (ver_next != hrlc_pkg::VER_ONE_ONE) begin
                status = hrlc_pkg::ST_VERSION;
            end else begin
                status = hrlc_pkg::ST_OK;
            end
        end
    end

    always_comb begin
        result.valid     = item.valid && (item.end_of_request || (do_path && !failed_next));
        result.item_kind = item.end_of_request ? hrlc_pkg::KIND_STATUS : hrlc_pkg::KIND_PATH;
        result.path_byte = item.end_of_request ? '0 : c;
        result.status    = item.end_of_request ? status : hrlc_pkg::ST_OK;
        result.root_path = item.end_of_request ? root : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && item.end_of_request)) begin
            phase_reg  <= hrlc_pkg::PH_METHOD;
            done_reg   <= 1'b0;
            pos_reg    <= '0;
            opt_reg    <= 1'b0;
            dot_reg    <= 1'b0;
            dotdot_reg <= 1'b0;
            plen_reg   <= hrlc_pkg::PLEN_NONE;
            ver_reg    <= '0;
            failed_reg <= 1'b0;
        end else if (take) begin
            phase_reg  <= phase_next;
            done_reg   <= done_next;
            pos_reg    <= pos_next;
            opt_reg    <= opt_next;
            dot_reg    <= dot_next;
            dotdot_reg <= dotdot_next;
            plen_reg   <= plen_next;
            ver_reg    <= ver_next;
            failed_reg <= failed_next;
        end
    end

endmodule

/* src/hrlc_out_reg.sv */
// Output register stage for path-byte and status items.
module hrlc_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hrlc_pkg::result_t              result,
    input  logic                           load,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hrlc_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);

    logic                           valid_reg, valid_next;
    logic                           kind_reg;
    logic [hrlc_pkg::BYTE_W-1:0]    byte_reg;
    logic [hrlc_pkg::STATUS_W-1:0]  status_reg;
    logic                           root_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= result.item_kind;
            byte_reg   <= result.path_byte;
            status_reg <= result.status;
            root_reg   <= result.root_path;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {5'd0, root_reg, status_reg, byte_reg};

endmodule

/* src/http_request_line_checker.sv */
// Top level of the HTTP request-line checker.
//
// Input channel s_: one request byte per item in s_tdata, s_tlast set on the
// final byte of a request. Output channel m_: one item per path byte that
// matches the pattern (m_tuser = 0, byte in m_tdata[7:0]) and one status
// item for the final byte (m_tuser = 1, status in m_tdata[9:8], root flag
// in m_tdata[10]). Bytes that produce no result are consumed silently.
// Throughput is one byte per cycle: the input register, the matcher logic
// and the output register form a two-stage pipeline, so a new byte is taken
// every cycle while the receiver keeps up; m_tvalid is driven by a register.
// The matcher state updates once per consumed byte; after the final byte it
// returns to the start of a request.
// When the receiver stalls, the output item holds, and the input register
// keeps taking bytes that produce no result; s_tready drops once a byte
// waiting for the output register is held. Reset (aresetn low, synchronous)
// clears both valid flags and returns the matcher to the start of a request.
module http_request_line_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hrlc_pkg::BYTE_W-1:0]    s_tdata,  // data_byte[7:0]
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hrlc_pkg::M_DATA_W-1:0]  m_tdata,  // path_byte[7:0], status[9:8], root_path[10]
    output logic                           m_tuser   // item_kind[0]
);

    hrlc_pkg::in_item_t item;
    hrlc_pkg::result_t  result;
    logic               out_free;
    logic               take;
    logic               load;

    assign out_free = !m_tvalid || m_tready;
    assign take     = item.valid && (out_free || !result.valid);
    assign load     = take && result.valid;

    hrlc_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .item     (item)
    );

    hrlc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .take    (take),
        .result  (result)
    );

    hrlc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* src/hrlc_checker.sv */
// Port-level checker for the HTTP request-line checker, with its bind.
module hrlc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hrlc_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                           m_tuser
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_status_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hrlc_pkg::KIND_STATUS |-> m_tdata[7:0] == 8'd0)
        else $error("status item carries a path byte");

    a_path_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == hrlc_pkg::KIND_PATH |-> m_tdata[10:8] == 3'd0)
        else $error("path item carries status or root flag");

    a_root_not_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[9:8] != hrlc_pkg::ST_INVALID)
        else $error("root flag set on an invalid request");

endmodule

bind http_request_line_checker hrlc_checker u_hrlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
